### rtl/core/top_k_logit_mask_assert.svh
// Assertion macros for the top-k logit mask checker
`ifndef TOP_K_LOGIT_MASK_ASSERT_SVH
`define TOP_K_LOGIT_MASK_ASSERT_SVH

// implication checked on every clock, off during reset
`define TKM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication with the consequent checked on the next clock
`define TKM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/tkm_pkg.sv
// Package for the top-k logit mask: widths, constants and the float order key
package tkm_pkg;
	localparam int MAX_KEEP_DEF = 64;
	localparam int MAX_VOCAB_DEF = 65536;
	localparam int KEEP_W = 7;
	localparam int LOGIT_W = 32;
	localparam logic [LOGIT_W-1:0] NEG_INF_BITS = 32'hFF80_0000;

	typedef enum logic {
		CMD_SCORE = 1'b0,
		CMD_FILTER = 1'b1
	} cmd_t;

	// maps float bits to an unsigned key with the same order; both zeros map alike
	function automatic logic [LOGIT_W-1:0] order_key(input logic [LOGIT_W-1:0] bits);
		logic [LOGIT_W-1:0] b;
		b = (bits[LOGIT_W-2:0] == '0) ? '0 : bits;
		if (b[LOGIT_W-1])
			return ~b;
		return b | {1'b1, {(LOGIT_W-1){1'b0}}};
	endfunction
endpackage

### rtl/core/top_k_logit_mask.sv
// Top level of the top-k logit mask: input register, cell chain, output register
//  channel | direction | content
//  s_axis  | in        | tdata logit, tuser command, tlast last; request
//  m_axis  | out       | tdata masked_logit, tuser kept, tlast end_of_vector
//  cfg     | in        | keep_count write
// One request per cycle, while s_axis_tready is high, enters the input register; it is applied
// to all cells in the next cycle.
// Scoring requests give no result; filter requests give one via the output register.
// arst_n clears cell valid bits, counters, keep_count and the output valid. No clearing pass.
// s_axis_tready drops only while a result waits in the output register and a filter
// request waits behind it in the input register.
module top_k_logit_mask import tkm_pkg::*; #(
	parameter int MAX_KEEP = MAX_KEEP_DEF,
	parameter int MAX_VOCAB = MAX_VOCAB_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,       // keep_count[6:0]
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [LOGIT_W-1:0] s_axis_tdata,    // logit
	input  logic               s_axis_tuser,    // command
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [LOGIT_W-1:0] m_axis_tdata,    // masked_logit
	output logic               m_axis_tuser,    // kept
	output logic               m_axis_tlast
);
	localparam int POS_W = (MAX_VOCAB > 1) ? $clog2(MAX_VOCAB) : 1;
	localparam int LEN_W = $clog2(MAX_VOCAB + 1);
	localparam int IDX_W = $clog2(MAX_KEEP + 1);
	localparam int CMP_W = (IDX_W > KEEP_W) ? IDX_W : KEEP_W;
	localparam int CNT_W = (LEN_W > KEEP_W) ? LEN_W : KEEP_W;

	logic [KEEP_W-1:0]  keep_count_q;
	logic [POS_W-1:0]   pos_counter_q;
	logic [LEN_W-1:0]   vec_len_q;

	logic               v_s1;
	cmd_t               cmd_s1;
	logic [LOGIT_W-1:0] logit_s1;
	logic               last_s1;
	logic [POS_W-1:0]   pos_s1;

	logic               out_v_q;
	logic [LOGIT_W-1:0] out_logit_q;
	logic               out_kept_q;
	logic               out_last_q;

	logic               stall;
	logic               acc;
	logic               score_go;
	logic               clear;
	logic [LOGIT_W-1:0] new_key;
	logic [CMP_W-1:0]   k_sat;

	logic [MAX_KEEP-1:0] c_valid, c_lt, c_hit;
	logic [LOGIT_W-1:0]  c_value [MAX_KEEP];
	logic [POS_W-1:0]    c_pos   [MAX_KEEP];

	assign stall = out_v_q && !m_axis_tready && v_s1 && (cmd_s1 == CMD_FILTER);
	assign s_axis_tready = !stall;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign score_go = v_s1 && (cmd_s1 == CMD_SCORE);
	assign clear = score_go && (pos_s1 == '0);
	assign new_key = order_key(logit_s1);
	assign k_sat = (CMP_W'(keep_count_q) > CMP_W'(MAX_KEEP)) ? CMP_W'(MAX_KEEP)
		: CMP_W'(keep_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= '0;
		end else if (cfg_we) begin
			keep_count_q <= cfg_wdata[KEEP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_counter_q <= '0;
			v_s1 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= acc;
			if (acc) begin
				if (s_axis_tlast)
					pos_counter_q <= '0;
				else if (pos_counter_q != POS_W'(MAX_VOCAB - 1))
					pos_counter_q <= pos_counter_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= cmd_t'(s_axis_tuser);
			logit_s1 <= s_axis_tdata;
			last_s1  <= s_axis_tlast;
			pos_s1   <= pos_counter_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_len_q <= '0;
		end else if (score_go) begin
			if (last_s1)
				vec_len_q <= LEN_W'(pos_s1) + 1'b1;
			else if (pos_s1 == '0)
				vec_len_q <= '0;
		end
	end

	genvar i;
	generate
		for (i = 0; i < MAX_KEEP; i++) begin : g_cell
			tkm_cell #(.POS_W(POS_W), .KEY_IDX_W(CMP_W)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.clear      (clear),
				.ins        (score_go),
				.new_value  (logit_s1),
				.new_key    (new_key),
				.new_pos    (pos_s1),
				.prev_valid ((i == 0) ? 1'b1 : c_valid[(i == 0) ? 0 : i-1]),
				.prev_lt    ((i == 0) ? 1'b0 : c_lt[(i == 0) ? 0 : i-1]),
				.prev_value (c_value[(i == 0) ? 0 : i-1]),
				.prev_pos   (c_pos[(i == 0) ? 0 : i-1]),
				.is_first   (i == 0),
				.probe_pos  (pos_s1),
				.index      (CMP_W'(i)),
				.limit      (k_sat),
				.valid      (c_valid[i]),
				.lt         (c_lt[i]),
				.value      (c_value[i]),
				.pos        (c_pos[i]),
				.hit        (c_hit[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			out_v_q <= v_s1 && (cmd_s1 == CMD_FILTER);
		end
	end

	always_ff @(posedge clk) begin
		if ((!out_v_q || m_axis_tready) && v_s1 && (cmd_s1 == CMD_FILTER)) begin
			if ((keep_count_q == '0) || (CNT_W'(keep_count_q) >= CNT_W'(vec_len_q))
				|| (|c_hit)) begin
				out_logit_q <= logit_s1;
				out_kept_q  <= 1'b1;
			end else begin
				out_logit_q <= NEG_INF_BITS;
				out_kept_q  <= 1'b0;
			end
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_logit_q;
	assign m_axis_tuser  = out_kept_q;
	assign m_axis_tlast  = out_last_q;
endmodule

### rtl/core/tkm_cell.sv
// One cell of the sorted insertion chain
module tkm_cell import tkm_pkg::*; #(
	parameter int POS_W = 16,
	parameter int KEY_IDX_W = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 ins,
	input  logic [LOGIT_W-1:0]   new_value,
	input  logic [LOGIT_W-1:0]   new_key,
	input  logic [POS_W-1:0]     new_pos,
	input  logic                 prev_valid,
	input  logic                 prev_lt,
	input  logic [LOGIT_W-1:0]   prev_value,
	input  logic [POS_W-1:0]     prev_pos,
	input  logic                 is_first,
	input  logic [POS_W-1:0]     probe_pos,
	input  logic [KEY_IDX_W-1:0] index,
	input  logic [KEY_IDX_W-1:0] limit,
	output logic                 valid,
	output logic                 lt,
	output logic [LOGIT_W-1:0]   value,
	output logic [POS_W-1:0]     pos,
	output logic                 hit
);
	logic                valid_q;
	logic [LOGIT_W-1:0]  value_q;
	logic [POS_W-1:0]    pos_q;
	logic                vld;

	// at the start of a scoring pass the cell looks empty to the new item
	assign vld   = valid_q && !clear;
	// the new item ranks above this cell when its key is strictly larger
	assign lt    = vld && (order_key(value_q) < new_key);
	assign valid = vld;
	assign value = value_q;
	assign pos   = pos_q;
	assign hit   = vld && (pos_q == probe_pos) && (index < limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins && (is_first || prev_valid)) begin
			valid_q <= 1'b1;
		end else if (clear) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			if (!is_first && prev_lt) begin
				value_q <= prev_value;
				pos_q   <= prev_pos;
			end else if (lt || !vld) begin
				value_q <= new_value;
				pos_q   <= new_pos;
			end
		end
	end
endmodule

### rtl/core/tkm_checker.sv
// Port-level checker for the top-k logit mask, bound to the top level
`include "top_k_logit_mask_assert.svh"
module tkm_checker import tkm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [LOGIT_W-1:0] m_axis_tdata,
	input logic               m_axis_tuser,
	input logic               m_axis_tlast
);
	logic               out_wait;
	logic [LOGIT_W+1:0] out_bits;

	assign out_wait = m_axis_tvalid && !m_axis_tready;
	assign out_bits = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

	`TKM_ASSERT_IMP(a_masked_value, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == NEG_INF_BITS)
	`TKM_ASSERT_IMP(a_ready_when_free, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`TKM_ASSERT_IMP(a_known, clk, arst_n, m_axis_tvalid, !$isunknown(out_bits))
	`TKM_ASSERT_NEXT(a_hold, clk, arst_n, out_wait, m_axis_tvalid && $stable(out_bits))
endmodule

bind top_k_logit_mask tkm_checker u_tkm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
